@@ hw/rtl/tdchtc_pkg.sv @@
// Shared types, widths and constants of the TDC hit time calibration block.
// Used by every module under hw/rtl; it depends on nothing else.
package tdchtc_pkg;

    // Table sizes
    localparam int BARREL_BARS    = 64;
    localparam int PROTO_CHANNELS = 16;
    localparam int OFFSET_DEPTH   = 128;
    localparam int GROUP_SIZE     = 8;
    localparam int NUM_GROUPS     = (BARREL_BARS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int BMAP_IDX_W     = (BARREL_BARS > 1) ? $clog2(BARREL_BARS) : 1;
    localparam int PMAP_IDX_W     = (PROTO_CHANNELS > 1) ? $clog2(PROTO_CHANNELS) : 1;
    localparam int SLOT_W         = $clog2(GROUP_SIZE);
    localparam int BAR_TOP_BASE   = 64;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 7;
    localparam int FPGA_W   = 4;
    localparam int CHAN_W   = 8;
    localparam int BARV_W   = 7;
    localparam int EPOCH_W  = 32;
    localparam int COARSE_W = 11;
    localparam int FINE_W   = 10;
    localparam int OFF_W    = 21;
    localparam int BAR_W    = 8;
    localparam int TIME_W   = 57;
    localparam int TSUM_W   = 58;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 2;

    // Arithmetic: one epoch is 625 << 14 ps, one coarse tick 5000 ps.
    localparam int E625_W      = 42;
    localparam int C5000_W     = 24;
    localparam int FNUM_W      = 23;
    localparam int BASE_W      = 56;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = FNUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 32;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int EPOCH_SHIFT = 14;

    localparam logic [9:0]         EPOCH_MUL  = 10'd625;
    localparam logic [12:0]        COARSE_PS  = 13'd5000;
    localparam logic [12:0]        FINE_PS    = 13'd5000;
    localparam logic [FINE_W-1:0]  FINE_ZERO  = 10'd17;
    localparam logic [FNUM_W-1:0]  FINE_ROUND = 23'd216;
    // ceil(2^32 / 433); exact floor division for numerators below 2^23
    localparam logic [RECIP_W-1:0] RECIP_M    = 24'd9919094;

    localparam logic signed [TSUM_W-1:0] TIME_MAX_PS = 58'sd43980465113000000;
    localparam logic signed [TSUM_W-1:0] TIME_MIN_PS = -58'sd2000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT           = 3'd0,
        CMD_WR_BARREL_MAP = 3'd1,
        CMD_WR_PROTO_MAP  = 3'd2,
        CMD_WR_BARREL_OFF = 3'd3,
        CMD_WR_PROTO_OFF  = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTO_MODE    = 2'd0,
        CFG_APPLY_OFFSETS = 2'd1,
        CFG_SKIP_UNCAL    = 2'd2
    } t_cfg_reg;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]          pad;
        logic [OFF_W-1:0]    offset_ps;
        logic [FINE_W-1:0]   fine_count;
        logic [COARSE_W-1:0] coarse_count;
        logic [EPOCH_W-1:0]  epoch_count;
        logic [BARV_W-1:0]   bar_value;
        logic [CHAN_W-1:0]   second_channel;
        logic [CHAN_W-1:0]   channel;
        logic [FPGA_W-1:0]   fpga_id;
        logic                rising_edge;
        logic [IDX_W-1:0]    table_index;
    } t_s_word;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [5:0]        pad;
        logic              offset_applied;
        logic [TIME_W-1:0] time_ps;
        logic [BAR_W-1:0]  bar_id;
    } t_m_word;

    typedef struct packed {
        logic              barrel_we;
        logic              proto_we;
        logic [IDX_W-1:0]  idx;
        logic [FPGA_W-1:0] fpga;
        logic [CHAN_W-1:0] top;
        logic [CHAN_W-1:0] bot;
        logic [BARV_W-1:0] bar;
    } t_map_wr;

    typedef struct packed {
        logic             barrel_we;
        logic             proto_we;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] value;
    } t_off_wr;

    typedef struct packed {
        logic             apply;
        logic             sel_proto;
        logic [IDX_W-1:0] addr;
    } t_off_rd;

    function automatic logic is_uncal_bar(input logic signed [BAR_W-1:0] b);
        return (b >= 8'sd0   && b <= 8'sd7)   || (b >= 8'sd48  && b <= 8'sd55) ||
               (b >= 8'sd64  && b <= 8'sd71)  || (b >= 8'sd112 && b <= 8'sd119);
    endfunction

endpackage

@@ hw/rtl/tdc_hit_time_calibration.sv @@
// Top level of the TDC hit time calibration block: pipeline control, filtering,
// offset subtraction and saturation. Depends on tdchtc_pkg and the three units.
//
//  Channel   Direction  Ports                         Content
//  s_axis    in         tvalid tready tdata tuser     command word (hit or table write)
//  m_axis    out        tvalid tready tdata           calibrated hit
//  cfg       in         i_cfg_valid o_cfg_ready       register index and data
//
// One word is taken per clock unless the output stalls. Each word passes through
// the five-stage pipeline: input register, map compare and first products,
// search merge and reciprocal product, offset read and time sum, offset
// subtract and saturate into the output register.
// Synchronous reset invalidates all map entries and makes all offsets read as zero.
// Each stage advances when the next one is empty or advancing, so bubbles close
// up under an output stall and nothing is dropped or repeated.
module tdc_hit_time_calibration (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // table_index, rising_edge, fpga_id, channel, second_channel, bar_value,
    // epoch_count, coarse_count, fine_count, offset_ps, zero fill
    input  logic [tdchtc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic [tdchtc_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // bar_id, time_ps, offset_applied, zero fill
    output logic [tdchtc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tdchtc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic                                   i_cfg_data
);
    import tdchtc_pkg::*;

    t_s_word in_word;
    t_m_word out_word;

    logic r_proto_mode, r_apply_offsets, r_skip_uncal;

    logic rdy1, rdy2, rdy3, rdy4, out_free;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [CMD_W-1:0]    r1_cmd, r2_cmd, r3_cmd;
    logic [IDX_W-1:0]    r1_idx, r2_idx, r3_idx;
    logic                r1_rising;
    logic [FPGA_W-1:0]   r1_fpga;
    logic [CHAN_W-1:0]   r1_chan, r1_chan2;
    logic [BARV_W-1:0]   r1_barv;
    logic [EPOCH_W-1:0]  r1_epoch;
    logic [COARSE_W-1:0] r1_coarse;
    logic [FINE_W-1:0]   r1_fine;
    logic [OFF_W-1:0]    r1_offv, r2_offv, r3_offv;
    logic                r2_hit, r3_hit;
    logic                r4_keep;
    logic [BAR_W-1:0]    r4_bar;

    t_map_wr map_wr;
    t_off_wr off_wr;
    t_off_rd off_rd;

    logic signed [BAR_W-1:0]  lk_bar;
    logic                     lk_found;
    logic                     n_keep;
    logic signed [TSUM_W-1:0] time4;
    logic signed [OFF_W-1:0]  offset4;
    logic                     applied4;
    logic signed [TSUM_W-1:0] n_time_sub;
    logic [TIME_W-1:0]        n_time_sat;

    logic                     r_mo_valid;
    logic [BAR_W-1:0]         r_mo_bar;
    logic [TIME_W-1:0]        r_mo_time;
    logic                     r_mo_applied;
    logic signed [TIME_W-1:0] out_time;

    assign in_word = s_axis_tdata;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto_mode    <= 1'b0;
            r_apply_offsets <= 1'b1;
            r_skip_uncal    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROTO_MODE:    r_proto_mode    <= i_cfg_data;
                CFG_APPLY_OFFSETS: r_apply_offsets <= i_cfg_data;
                CFG_SKIP_UNCAL:    r_skip_uncal    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advance chain
    always_comb begin
        out_free      = !r_mo_valid || m_axis_tready;
        rdy4          = !r_v4 || out_free;
        rdy3          = !r_v3 || rdy4;
        rdy2          = !r_v2 || rdy3;
        rdy1          = !r_v1 || rdy2;
        s_axis_tready = rdy1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_cmd    <= s_axis_tuser;
            r1_idx    <= in_word.table_index;
            r1_rising <= in_word.rising_edge;
            r1_fpga   <= in_word.fpga_id;
            r1_chan   <= in_word.channel;
            r1_chan2  <= in_word.second_channel;
            r1_barv   <= in_word.bar_value;
            r1_epoch  <= in_word.epoch_count;
            r1_coarse <= in_word.coarse_count;
            r1_fine   <= in_word.fine_count;
            r1_offv   <= in_word.offset_ps;
        end
    end

    // Map writes land as the word leaves stage 1, where later hits compare.
    always_comb begin
        map_wr.barrel_we = r_v1 && rdy2 && (r1_cmd == CMD_WR_BARREL_MAP) &&
                           (r1_idx < IDX_W'(BARREL_BARS));
        map_wr.proto_we  = r_v1 && rdy2 && (r1_cmd == CMD_WR_PROTO_MAP) &&
                           (r1_idx < IDX_W'(PROTO_CHANNELS));
        map_wr.idx       = r1_idx;
        map_wr.fpga      = r1_fpga;
        map_wr.top       = r1_chan;
        map_wr.bot       = r1_chan2;
        map_wr.bar       = r1_barv;
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_cmd  <= r1_cmd;
            r2_idx  <= r1_idx;
            r2_offv <= r1_offv;
            r2_hit  <= (r1_cmd == CMD_HIT) && r1_rising && (r1_chan != '0);
        end
        if (rdy3) begin
            r3_cmd  <= r2_cmd;
            r3_idx  <= r2_idx;
            r3_offv <= r2_offv;
            r3_hit  <= r2_hit;
        end
    end

    tdchtc_bar_lookup u_lookup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en2        (rdy2),
        .i_en3        (rdy3),
        .i_proto_mode (r_proto_mode),
        .i_wr         (map_wr),
        .i_fpga       (r1_fpga),
        .i_chan       (r1_chan),
        .o_bar        (lk_bar),
        .o_found      (lk_found)
    );

    tdchtc_time_calc u_time (
        .i_clk    (i_clk),
        .i_en2    (rdy2),
        .i_en3    (rdy3),
        .i_en4    (rdy4),
        .i_epoch  (r1_epoch),
        .i_coarse (r1_coarse),
        .i_fine   (r1_fine),
        .o_time   (time4)
    );

    // Stage 3 to 4: filter, offset lookup and offset table writes.
    always_comb begin
        n_keep = r3_hit && !(r_skip_uncal && lk_found && is_uncal_bar(lk_bar));

        off_rd.sel_proto = r_proto_mode;
        off_rd.addr      = lk_bar[IDX_W-1:0];
        off_rd.apply     = r_apply_offsets && lk_found &&
                           (!r_proto_mode || (lk_bar[IDX_W-1:0] < IDX_W'(PROTO_CHANNELS)));

        off_wr.barrel_we = r_v3 && rdy4 && (r3_cmd == CMD_WR_BARREL_OFF);
        off_wr.proto_we  = r_v3 && rdy4 && (r3_cmd == CMD_WR_PROTO_OFF) &&
                           (r3_idx < IDX_W'(PROTO_CHANNELS));
        off_wr.idx       = r3_idx;
        off_wr.value     = r3_offv;
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_keep <= n_keep;
            r4_bar  <= lk_bar;
        end
    end

    tdchtc_offset_store u_offsets (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en4     (rdy4),
        .i_wr      (off_wr),
        .i_rd      (off_rd),
        .o_offset  (offset4),
        .o_applied (applied4)
    );

    // Stage 4 to output: subtract the offset and clamp to the output range.
    always_comb begin
        n_time_sub = time4 - TSUM_W'(offset4);
        if (n_time_sub > TIME_MAX_PS) begin
            n_time_sat = TIME_MAX_PS[TIME_W-1:0];
        end else if (n_time_sub < TIME_MIN_PS) begin
            n_time_sat = TIME_MIN_PS[TIME_W-1:0];
        end else begin
            n_time_sat = n_time_sub[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mo_valid <= 1'b0;
        end else if (out_free) begin
            r_mo_valid <= r_v4 && r4_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_mo_bar     <= r4_bar;
            r_mo_time    <= n_time_sat;
            r_mo_applied <= applied4;
        end
    end

    always_comb begin
        out_word.pad            = '0;
        out_word.offset_applied = r_mo_applied;
        out_word.time_ps        = r_mo_time;
        out_word.bar_id         = r_mo_bar;
        m_axis_tdata            = out_word;
        m_axis_tvalid           = r_mo_valid;
        out_time                = $signed(r_mo_time);
    end

    ap_applied_has_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_mo_applied) |-> !r_mo_bar[BAR_W-1])
        else $error("offset applied to a hit without a bar");

    ap_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (TSUM_W'(out_time) <= TIME_MAX_PS &&
                           TSUM_W'(out_time) >= TIME_MIN_PS))
        else $error("output time outside the saturation range");

    ap_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !rdy4) |=> (r_v4 && $stable(r4_bar) && $stable(r4_keep)))
        else $error("stage 4 word changed while stalled");

    ap_writes_give_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4 && (r3_cmd != CMD_HIT)) |=> !r4_keep)
        else $error("table write word marked as a result");

endmodule

@@ hw/rtl/tdchtc_bar_lookup.sv @@
// Bar lookup: barrel and prototype channel maps with parallel first-match search.
// Two register stages (group results, then bar). Depends on tdchtc_pkg.
module tdchtc_bar_lookup (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en2,
    input  logic                                 i_en3,
    input  logic                                 i_proto_mode,
    input  tdchtc_pkg::t_map_wr                  i_wr,
    input  logic [tdchtc_pkg::FPGA_W-1:0]        i_fpga,
    input  logic [tdchtc_pkg::CHAN_W-1:0]        i_chan,
    output logic signed [tdchtc_pkg::BAR_W-1:0]  o_bar,
    output logic                                 o_found
);
    import tdchtc_pkg::*;

    logic                  r_bm_vld  [BARREL_BARS];
    logic [FPGA_W-1:0]     r_bm_fpga [BARREL_BARS];
    logic [CHAN_W-1:0]     r_bm_top  [BARREL_BARS];
    logic [CHAN_W-1:0]     r_bm_bot  [BARREL_BARS];
    logic                  r_pm_vld  [PROTO_CHANNELS];
    logic [CHAN_W-1:0]     r_pm_chan [PROTO_CHANNELS];
    logic [BARV_W-1:0]     r_pm_bar  [PROTO_CHANNELS];

    logic [BARREL_BARS-1:0] bm_hit;
    logic [BARREL_BARS-1:0] bm_top_hit;

    logic [NUM_GROUPS-1:0] n_g_found, r_g_found;
    logic [NUM_GROUPS-1:0] n_g_top,   r_g_top;
    logic [SLOT_W-1:0]     n_g_slot [NUM_GROUPS];
    logic [SLOT_W-1:0]     r_g_slot [NUM_GROUPS];
    logic                  n_p_found, r_p_found;
    logic [BARV_W-1:0]     n_p_bar,   r_p_bar;
    logic [BAR_W-1:0]      n_bar;
    logic                  n_found;

    // Valid bits clear at reset; entry contents need none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BARREL_BARS; i++) r_bm_vld[i] <= 1'b0;
            for (int i = 0; i < PROTO_CHANNELS; i++) r_pm_vld[i] <= 1'b0;
        end else begin
            if (i_wr.barrel_we) r_bm_vld[i_wr.idx[BMAP_IDX_W-1:0]] <= 1'b1;
            if (i_wr.proto_we) r_pm_vld[i_wr.idx[PMAP_IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.barrel_we) begin
            r_bm_fpga[i_wr.idx[BMAP_IDX_W-1:0]] <= i_wr.fpga;
            r_bm_top[i_wr.idx[BMAP_IDX_W-1:0]]  <= i_wr.top;
            r_bm_bot[i_wr.idx[BMAP_IDX_W-1:0]]  <= i_wr.bot;
        end
        if (i_wr.proto_we) begin
            r_pm_chan[i_wr.idx[PMAP_IDX_W-1:0]] <= i_wr.top;
            r_pm_bar[i_wr.idx[PMAP_IDX_W-1:0]]  <= i_wr.bar;
        end
    end

    always_comb begin
        for (int i = 0; i < BARREL_BARS; i++) begin
            bm_top_hit[i] = (r_bm_top[i] == i_chan);
            bm_hit[i]     = r_bm_vld[i] && (r_bm_fpga[i] == i_fpga) &&
                            (bm_top_hit[i] || (r_bm_bot[i] == i_chan));
        end
    end

    // First match inside each group of eight; the lowest slot wins.
    always_comb begin
        n_g_found = '0;
        n_g_top   = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_g_slot[g] = '0;
            for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
                if (g * GROUP_SIZE + k < BARREL_BARS) begin
                    if (bm_hit[g * GROUP_SIZE + k]) begin
                        n_g_found[g] = 1'b1;
                        n_g_slot[g]  = SLOT_W'(k);
                        n_g_top[g]   = bm_top_hit[g * GROUP_SIZE + k];
                    end
                end
            end
        end
        n_p_found = 1'b0;
        n_p_bar   = '0;
        for (int j = PROTO_CHANNELS - 1; j >= 0; j--) begin
            if (r_pm_vld[j] && (r_pm_chan[j] == i_chan)) begin
                n_p_found = 1'b1;
                n_p_bar   = r_pm_bar[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_g_found <= n_g_found;
            r_g_top   <= n_g_top;
            r_g_slot  <= n_g_slot;
            r_p_found <= n_p_found;
            r_p_bar   <= n_p_bar;
        end
    end

    // Second level of the search: the lowest group with a match wins.
    always_comb begin
        n_bar   = '1;
        n_found = 1'b0;
        if (i_proto_mode) begin
            if (r_p_found) begin
                n_found = 1'b1;
                n_bar   = {1'b0, r_p_bar};
            end
        end else begin
            for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
                if (r_g_found[g]) begin
                    n_found = 1'b1;
                    n_bar   = BAR_W'(g * GROUP_SIZE) + BAR_W'(r_g_slot[g]) +
                              (r_g_top[g] ? BAR_W'(BAR_TOP_BASE) : BAR_W'(0));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            o_bar   <= $signed(n_bar);
            o_found <= n_found;
        end
    end

endmodule

@@ hw/rtl/tdchtc_time_calc.sv @@
// Hit time arithmetic: epoch, coarse and rounded fine correction in picoseconds.
// Three register stages; the multipliers sit in the first two. Depends on tdchtc_pkg.
module tdchtc_time_calc (
    input  logic                                  i_clk,
    input  logic                                  i_en2,
    input  logic                                  i_en3,
    input  logic                                  i_en4,
    input  logic [tdchtc_pkg::EPOCH_W-1:0]        i_epoch,
    input  logic [tdchtc_pkg::COARSE_W-1:0]       i_coarse,
    input  logic [tdchtc_pkg::FINE_W-1:0]         i_fine,
    output logic signed [tdchtc_pkg::TSUM_W-1:0]  o_time
);
    import tdchtc_pkg::*;

    logic [E625_W-1:0]  r_e625;
    logic [C5000_W-1:0] r_c5000;
    logic [FNUM_W-1:0]  r_fnum;
    logic               r_dneg2, r_dneg3;
    logic [BASE_W-1:0]  r_base;
    logic [PROD_W-1:0]  r_prod;
    logic               n_dneg;
    logic [FINE_W-1:0]  n_dmag;
    logic [QUO_W-1:0]   quo;
    logic [TSUM_W-1:0]  n_time;

    // The fine correction rounds half away from zero on |fine - 17| * 5000.
    always_comb begin
        n_dneg = i_fine < FINE_ZERO;
        n_dmag = n_dneg ? (FINE_ZERO - i_fine) : (i_fine - FINE_ZERO);
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_e625  <= E625_W'(i_epoch) * E625_W'(EPOCH_MUL);
            r_c5000 <= C5000_W'(i_coarse) * C5000_W'(COARSE_PS);
            r_fnum  <= FNUM_W'(n_dmag) * FNUM_W'(FINE_PS) + FINE_ROUND;
            r_dneg2 <= n_dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_base  <= {r_e625, EPOCH_SHIFT'(0)} + BASE_W'(r_c5000);
            r_prod  <= PROD_W'(r_fnum) * PROD_W'(RECIP_M);
            r_dneg3 <= r_dneg2;
        end
    end

    always_comb begin
        quo = r_prod[PROD_W-1:RECIP_SHIFT];
        if (r_dneg3) begin
            n_time = TSUM_W'(r_base) + TSUM_W'(quo);
        end else begin
            n_time = TSUM_W'(r_base) - TSUM_W'(quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            o_time <= $signed(n_time);
        end
    end

endmodule

@@ hw/rtl/tdchtc_offset_store.sv @@
// Per-bar delay offsets: 128-entry barrel memory with valid bits and a small
// prototype register file. Read data registered. Depends on tdchtc_pkg.
module tdchtc_offset_store (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en4,
    input  tdchtc_pkg::t_off_wr                  i_wr,
    input  tdchtc_pkg::t_off_rd                  i_rd,
    output logic signed [tdchtc_pkg::OFF_W-1:0]  o_offset,
    output logic                                 o_applied
);
    import tdchtc_pkg::*;

    logic [OFF_W-1:0] r_bo_mem [OFFSET_DEPTH];
    logic             r_bo_vld [OFFSET_DEPTH];
    logic [OFF_W-1:0] r_po     [PROTO_CHANNELS];
    logic [OFF_W-1:0] r_bo_rd;
    logic             r_bo_rdv;
    logic [OFF_W-1:0] r_po_rd;
    logic             r_apply;
    logic             r_sel_proto;

    always_ff @(posedge i_clk) begin
        if (i_wr.barrel_we) r_bo_mem[i_wr.idx] <= i_wr.value;
        if (i_en4) r_bo_rd <= r_bo_mem[i_rd.addr];
    end

    // An entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < OFFSET_DEPTH; i++) r_bo_vld[i] <= 1'b0;
            for (int i = 0; i < PROTO_CHANNELS; i++) r_po[i] <= '0;
        end else begin
            if (i_wr.barrel_we) r_bo_vld[i_wr.idx] <= 1'b1;
            if (i_wr.proto_we) r_po[i_wr.idx[PMAP_IDX_W-1:0]] <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_bo_rdv    <= r_bo_vld[i_rd.addr];
            r_po_rd     <= r_po[i_rd.addr[PMAP_IDX_W-1:0]];
            r_apply     <= i_rd.apply;
            r_sel_proto <= i_rd.sel_proto;
        end
    end

    always_comb begin
        o_applied = r_apply;
        if (!r_apply) begin
            o_offset = '0;
        end else if (r_sel_proto) begin
            o_offset = $signed(r_po_rd);
        end else if (r_bo_rdv) begin
            o_offset = $signed(r_bo_rd);
        end else begin
            o_offset = '0;
        end
    end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for tdc_hit_time_calibration: directed table, then random phases.
// A predictor in this file computes the calibrated hits; it needs only tdchtc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import tdchtc_pkg::*;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     DRAIN_CYCLES = 10;
    localparam int     PHASE_WORDS  = 240;
    localparam int     NUM_PHASES   = 8;
    localparam longint T_CEIL       = 64'sd43980465113000000;
    localparam longint T_FLOOR      = -64'sd2000000;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {CHK_MODEL, CHK_NONE, CHK_VALUE} t_chk;

    typedef struct packed {
        logic signed [BAR_W-1:0] bar;
        logic [TIME_W-1:0]       time_ps;
        logic                    applied;
    } t_cal_hit;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        t_s_word          w;
        t_chk             chk;
        t_cal_hit         fixed;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;

    tdc_hit_time_calibration u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of the lookup tables and mode bits
    bit                      mode_proto, mode_apply, mode_skip;
    bit                      bmap_valid [BARREL_BARS];
    logic [FPGA_W-1:0]       bmap_fpga  [BARREL_BARS];
    logic [CHAN_W-1:0]       bmap_top   [BARREL_BARS];
    logic [CHAN_W-1:0]       bmap_bot   [BARREL_BARS];
    bit                      pmap_valid [PROTO_CHANNELS];
    logic [CHAN_W-1:0]       pmap_chan  [PROTO_CHANNELS];
    logic [BARV_W-1:0]       pmap_bar   [PROTO_CHANNELS];
    logic signed [OFF_W-1:0] bar_delay  [OFFSET_DEPTH];
    logic signed [OFF_W-1:0] chan_delay [PROTO_CHANNELS];

    t_cal_hit pending_hits[$];
    t_row     directed_rows[$];
    int       fail_count, results_seen, hits_sent, others_sent, cycle_count;
    int       src_calm, snk_calm, snk_stall;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] %s mismatch: got %h, wanted %h (result %0d)",
                     $time, what, got, want, results_seen);
    endtask

    task automatic calibrate_word(input logic [CMD_W-1:0] cmd, input t_s_word w,
                                  output bit emits, output t_cal_hit res);
        int     i;
        int     bar;
        bit     found;
        longint t, d, fc;
        emits = 1'b0;
        res   = '0;
        found = 1'b0;
        bar   = -1;
        case (cmd)
            CMD_WR_BARREL_MAP: begin
                if (w.table_index < BARREL_BARS) begin
                    bmap_valid[w.table_index] = 1'b1;
                    bmap_fpga[w.table_index]  = w.fpga_id;
                    bmap_top[w.table_index]   = w.channel;
                    bmap_bot[w.table_index]   = w.second_channel;
                end
            end
            CMD_WR_PROTO_MAP: begin
                if (w.table_index < PROTO_CHANNELS) begin
                    pmap_valid[w.table_index] = 1'b1;
                    pmap_chan[w.table_index]  = w.channel;
                    pmap_bar[w.table_index]   = w.bar_value;
                end
            end
            CMD_WR_BARREL_OFF: bar_delay[w.table_index] = w.offset_ps;
            CMD_WR_PROTO_OFF: begin
                if (w.table_index < PROTO_CHANNELS) chan_delay[w.table_index] = w.offset_ps;
            end
            CMD_HIT: begin
                if (w.rising_edge && w.channel != '0) begin
                    if (mode_proto) begin
                        for (i = 0; i < PROTO_CHANNELS; i++)
                            if (!found && pmap_valid[i] && pmap_chan[i] == w.channel) begin
                                bar   = pmap_bar[i];
                                found = 1'b1;
                            end
                    end else begin
                        // Top end wins over bottom end only within the same entry.
                        for (i = 0; i < BARREL_BARS; i++)
                            if (!found && bmap_valid[i] && bmap_fpga[i] == w.fpga_id) begin
                                if (bmap_top[i] == w.channel) begin
                                    bar   = i + 64;
                                    found = 1'b1;
                                end else if (bmap_bot[i] == w.channel) begin
                                    bar   = i;
                                    found = 1'b1;
                                end
                            end
                    end
                    if (!(mode_skip && ((bar >= 0 && bar <= 7) || (bar >= 48 && bar <= 55) ||
                          (bar >= 64 && bar <= 71) || (bar >= 112 && bar <= 119)))) begin
                        d  = (longint'(w.fine_count) - 17) * 5000;
                        fc = (d >= 0) ? (d + 216) / 433 : -((-d + 216) / 433);
                        t  = longint'({32'd0, w.epoch_count}) * 10240000
                             + longint'(w.coarse_count) * 5000 - fc;
                        if (mode_apply && bar >= 0) begin
                            if (mode_proto && bar < PROTO_CHANNELS) begin
                                t           = t - longint'(chan_delay[bar]);
                                res.applied = 1'b1;
                            end else if (!mode_proto && bar < OFFSET_DEPTH) begin
                                t           = t - longint'(bar_delay[bar]);
                                res.applied = 1'b1;
                            end
                        end
                        if (t > T_CEIL) t = T_CEIL;
                        if (t < T_FLOOR) t = T_FLOOR;
                        res.bar     = bar[BAR_W-1:0];
                        res.time_ps = t[TIME_W-1:0];
                        emits       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_src_gap();
        int r;
        if (src_calm > 0) begin
            src_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) src_calm = $urandom_range(30, 80);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_word(input logic [CMD_W-1:0] cmd, input t_s_word w,
                             input t_chk chk, input t_cal_hit fixed);
        int       gap;
        bit       emits;
        t_cal_hit res;
        gap = pick_src_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        calibrate_word(cmd, w, emits, res);
        if (chk == CHK_VALUE) pending_hits.push_back(fixed);
        else if (chk == CHK_MODEL && emits) pending_hits.push_back(res);
        if (cmd == CMD_HIT) hits_sent++;
        else others_sent++;
    endtask

    task automatic wait_drain();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input bit pm, input bit ao, input bit sk);
        t_cfg_reg regs[3];
        bit       vals[3];
        int       r;
        regs = '{CFG_PROTO_MODE, CFG_APPLY_OFFSETS, CFG_SKIP_UNCAL};
        vals = '{pm, ao, sk};
        for (r = 0; r < 3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        mode_proto = pm;
        mode_apply = ao;
        mode_skip  = sk;
    endtask

    function automatic t_row mk_hit(input bit rise, input logic [FPGA_W-1:0] fpga,
                                    input logic [CHAN_W-1:0] ch, input logic [EPOCH_W-1:0] ep,
                                    input logic [COARSE_W-1:0] co, input logic [FINE_W-1:0] fi,
                                    input t_chk chk, input int bar, input longint tps);
        t_row r;
        r.cmd                = CMD_HIT;
        r.w                  = '0;
        r.w.rising_edge      = rise;
        r.w.fpga_id          = fpga;
        r.w.channel          = ch;
        r.w.epoch_count      = ep;
        r.w.coarse_count     = co;
        r.w.fine_count       = fi;
        r.chk                = chk;
        r.fixed.bar          = bar[BAR_W-1:0];
        r.fixed.time_ps      = tps[TIME_W-1:0];
        r.fixed.applied      = 1'b0;
        return r;
    endfunction

    function automatic t_row mk_tbl(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                    input logic [FPGA_W-1:0] fpga, input logic [CHAN_W-1:0] ch,
                                    input logic [CHAN_W-1:0] ch2, input logic [BARV_W-1:0] barv,
                                    input logic [OFF_W-1:0] off);
        t_row r;
        r.cmd              = cmd;
        r.w                = '0;
        r.w.table_index    = idx;
        r.w.fpga_id        = fpga;
        r.w.channel        = ch;
        r.w.second_channel = ch2;
        r.w.bar_value      = barv;
        r.w.offset_ps      = off;
        r.chk              = CHK_MODEL;
        r.fixed            = '0;
        return r;
    endfunction

    task automatic random_word(output logic [CMD_W-1:0] cmd, output t_s_word w);
        logic [127:0] raw;
        int           r;
        raw   = {$urandom, $urandom, $urandom, $urandom};
        w     = raw[S_TDATA_W-1:0];
        w.pad = '0;
        r     = $urandom_range(0, 99);
        if (r < 7) begin
            cmd              = CMD_WR_BARREL_MAP;
            w.table_index    = $urandom_range(0, BARREL_BARS + 7);
            w.fpga_id        = $urandom_range(0, 3);
            w.channel        = $urandom_range(1, 24);
            w.second_channel = $urandom_range(1, 24);
        end else if (r < 11) begin
            cmd           = CMD_WR_PROTO_MAP;
            w.table_index = $urandom_range(0, PROTO_CHANNELS + 3);
            w.channel     = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) w.bar_value = $urandom_range(0, 20);
        end else if (r < 15) begin
            cmd = CMD_WR_BARREL_OFF;
        end else if (r < 18) begin
            cmd           = CMD_WR_PROTO_OFF;
            w.table_index = $urandom_range(0, PROTO_CHANNELS + 3);
        end else if (r < 20) begin
            cmd = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
        end else begin
            cmd           = CMD_HIT;
            w.rising_edge = ($urandom_range(0, 9) != 0);
            r             = $urandom_range(0, 19);
            if (r == 0) begin
                w.channel = '0;
            end else if (r < 15) begin
                w.channel = $urandom_range(1, 24);
                w.fpga_id = $urandom_range(0, 3);
            end
            case ($urandom_range(0, 3))
                0:       w.epoch_count = $urandom_range(0, 3);
                1:       w.epoch_count = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: ;
            endcase
        end
    endtask

    // Output side: random back-pressure and the result check.
    always @(posedge i_clk) begin : sink
        t_m_word  got;
        t_cal_hit want;
        int       r;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            results_seen++;
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, '0);
            end else begin
                want = pending_hits.pop_front();
                if (got.bar_id !== want.bar)
                    report_mismatch("bar_id", got.bar_id, want.bar);
                if (got.time_ps !== want.time_ps)
                    report_mismatch("time_ps", got.time_ps, want.time_ps);
                if (got.offset_applied !== want.applied)
                    report_mismatch("offset_applied", got.offset_applied, want.applied);
            end
        end
        if (snk_stall > 0) begin
            snk_stall--;
            m_axis_tready <= 1'b0;
        end else if (snk_calm > 0) begin
            snk_calm--;
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                snk_calm = $urandom_range(30, 80);
                m_axis_tready <= 1'b1;
            end else if (r < 65) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (r < 88) snk_stall = $urandom_range(0, 2);
                else if (r < 97) snk_stall = $urandom_range(3, 11);
                else snk_stall = $urandom_range(19, 49);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_hits.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0] cmd;
        t_s_word          w;
        bit               phase_mode[NUM_PHASES][3];
        int               i, p, n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_HIT;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PROTO_MODE;
        i_cfg_data    <= 1'b0;

        mode_proto = 1'b0;
        mode_apply = 1'b1;
        mode_skip  = 1'b1;
        for (i = 0; i < BARREL_BARS; i++) bmap_valid[i] = 1'b0;
        for (i = 0; i < PROTO_CHANNELS; i++) begin
            pmap_valid[i] = 1'b0;
            chan_delay[i] = '0;
        end
        for (i = 0; i < OFFSET_DEPTH; i++) bar_delay[i] = '0;

        // Hits on empty maps carry no bar and no offset, so their times are plain arithmetic.
        directed_rows.push_back(mk_hit(1, 0, 1, 0, 0, 17, CHK_VALUE, -1, 0));
        directed_rows.push_back(mk_hit(0, 0, 1, 0, 0, 17, CHK_NONE, 0, 0));
        directed_rows.push_back(mk_hit(1, 0, 0, 0, 0, 17, CHK_NONE, 0, 0));
        directed_rows.push_back(mk_hit(1, 15, 255, 32'hFFFF_FFFF, 2047, 0, CHK_VALUE, -1,
                                       64'sd43980465111035196));
        directed_rows.push_back(mk_hit(1, 0, 1, 0, 0, 1023, CHK_VALUE, -1, -64'sd11617));
        directed_rows.push_back(mk_hit(1, 0, 1, 0, 2047, 450, CHK_VALUE, -1, 64'sd10230000));
        directed_rows.push_back(mk_tbl(CMD_SPARE_HI, 5, 3, 20, 21, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_MAP, 10, 3, 20, 21, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_MAP, 63, 15, 255, 254, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_MAP, 64, 3, 30, 31, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_MAP, 2, 3, 40, 41, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_OFF, 74, 0, 0, 0, 0, 21'h100000));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_OFF, 10, 0, 0, 0, 0, 21'h0FFFFF));
        directed_rows.push_back(mk_tbl(CMD_WR_BARREL_OFF, 127, 0, 0, 0, 0, 21'd12345));
        directed_rows.push_back(mk_hit(1, 3, 20, 7, 100, 200, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_hit(1, 3, 21, 0, 0, 17, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_hit(1, 3, 30, 9, 9, 9, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_hit(1, 3, 40, 1, 1, 1, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_hit(1, 3, 41, 1, 1, 1, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_hit(1, 15, 255, 32'hFFFF_FFFF, 2047, 1023, CHK_MODEL, 0, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_PROTO_MAP, 0, 0, 5, 0, 3, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_PROTO_MAP, 15, 0, 6, 0, 127, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_PROTO_MAP, 16, 0, 7, 0, 1, 0));
        directed_rows.push_back(mk_tbl(CMD_WR_PROTO_OFF, 3, 0, 0, 0, 0, -21'sd5000));
        directed_rows.push_back(mk_tbl(CMD_WR_PROTO_OFF, 16, 0, 0, 0, 0, 21'd777));

        phase_mode = '{'{0, 1, 1}, '{0, 0, 0}, '{1, 1, 1}, '{1, 0, 1},
                       '{0, 1, 0}, '{1, 1, 0}, '{0, 0, 1}, '{1, 0, 0}};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_word(directed_rows[i].cmd, directed_rows[i].w, directed_rows[i].chk,
                      directed_rows[i].fixed);
        s_axis_tvalid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            set_mode(phase_mode[p][0], phase_mode[p][1], phase_mode[p][2]);
            for (n = 0; n < PHASE_WORDS; n++) begin
                random_word(cmd, w);
                push_word(cmd, w, CHK_MODEL, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_drain();
        if (pending_hits.size() != 0)
            report_mismatch("results never delivered", pending_hits.size(), '0);
        $display("Sent %0d hits and %0d table or spare words under %0d register settings.",
                 hits_sent, others_sent, NUM_PHASES + 1);
        $display("Compared %0d calibrated hits against the predictor; %0d mismatches.",
                 results_seen, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
